FILE: sv/u8sd_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// No dependencies; every other file of the block imports this package.
package u8sd_pkg;

    localparam int BYTE_W     = 8;
    localparam int CP_W       = 31;
    localparam int CNT_W      = 3;
    localparam int M_TDATA_W  = ((CP_W + CNT_W + 7) / 8) * 8;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [BYTE_W-1:0] CONT_BITS_MASK = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK     = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK     = 8'h0F;
    localparam logic [BYTE_W-1:0] LEAD4_MASK     = 8'h07;
    localparam logic [BYTE_W-1:0] LEAD5_MASK     = 8'h03;
    localparam logic [BYTE_W-1:0] LEAD6_MASK     = 8'h01;

    localparam logic [CNT_W-1:0] LEN_1 = 3'd1;
    localparam logic [CNT_W-1:0] LEN_2 = 3'd2;
    localparam logic [CNT_W-1:0] LEN_3 = 3'd3;
    localparam logic [CNT_W-1:0] LEN_4 = 3'd4;
    localparam logic [CNT_W-1:0] LEN_5 = 3'd5;
    localparam logic [CNT_W-1:0] LEN_6 = 3'd6;

    // What the back end does with a queued byte.
    typedef enum logic [2:0] {
        TOK_PASS = 3'b001,   // emit the byte itself, count 1, drop any partial
        TOK_LEAD = 3'b010,   // seed a multi-byte sequence
        TOK_CONT = 3'b100    // shift in six continuation bits
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t         kind;
        logic              last;   // continuation that completes the character
        logic [CNT_W-1:0]  len;    // sequence length, valid on TOK_LEAD
        logic [BYTE_W-1:0] data;   // byte, seed or continuation bits
    } token_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Lead byte with both top bits set: sequence length.
    function automatic logic [CNT_W-1:0] lead_len(input logic [BYTE_W-1:0] b);
        logic [CNT_W-1:0] len;
        begin
            if (!b[5])      len = LEN_2;
            else if (!b[4]) len = LEN_3;
            else if (!b[3]) len = LEN_4;
            else if (!b[2]) len = LEN_5;
            else            len = LEN_6;
            return len;
        end
    endfunction

    // Lead byte with both top bits set: payload bits that seed the value.
    function automatic logic [BYTE_W-1:0] lead_seed(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] seed;
        begin
            if (!b[5])      seed = b & LEAD2_MASK;
            else if (!b[4]) seed = b & LEAD3_MASK;
            else if (!b[3]) seed = b & LEAD4_MASK;
            else if (!b[2]) seed = b & LEAD5_MASK;
            else            seed = b & LEAD6_MASK;
            return seed;
        end
    endfunction

endpackage

FILE: sv/u8sd_front.sv
// Front end: takes input bytes, holds the mode register and the sequence
// position, and turns each byte into a token for the queue. Uses u8sd_pkg.
module u8sd_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u8sd_pkg::BYTE_W-1:0]   s_tdata,
    input  u8sd_pkg::fifo_stat_t          fifo_stat,
    output logic                          push,
    output u8sd_pkg::token_t              push_tok,
    output logic                          utf8_mode
);
    import u8sd_pkg::*;

    logic             mode_reg, mode_next;
    logic [CNT_W-1:0] left_reg, left_next;
    logic [CNT_W-1:0] len;
    token_t           tok;

    assign cfg_ready = 1'b1;
    assign s_tready  = !fifo_stat.full;
    assign push      = s_tvalid && s_tready;
    assign push_tok  = tok;
    assign utf8_mode = mode_reg;

    assign mode_next = (cfg_valid && cfg_ready) ? cfg_data : mode_reg;

    always_comb begin
        len       = lead_len(s_tdata);
        tok.kind  = TOK_PASS;
        tok.last  = 1'b0;
        tok.len   = LEN_1;
        tok.data  = s_tdata;
        left_next = left_reg;
        if (!mode_reg) begin
            left_next = '0;
        end else if (left_reg == '0) begin
            if (s_tdata[7] && s_tdata[6]) begin
                tok.kind  = TOK_LEAD;
                tok.len   = len;
                tok.data  = lead_seed(s_tdata);
                left_next = len - LEN_1;
            end
        end else begin
            tok.kind  = TOK_CONT;
            tok.data  = s_tdata & CONT_BITS_MASK;
            tok.last  = (left_reg == LEN_1);
            left_next = left_reg - LEN_1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
            left_reg <= '0;
        end else begin
            mode_reg <= mode_next;
            if (push) begin
                left_reg <= left_next;
            end
        end
    end

endmodule

FILE: sv/u8sd_fifo.sv
// Short token queue between front and back end.
// Uses u8sd_pkg for the token type, depth and status struct.
module u8sd_fifo (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  u8sd_pkg::token_t     push_tok,
    input  logic                 pop,
    output u8sd_pkg::token_t     pop_tok,
    output u8sd_pkg::fifo_stat_t stat
);
    import u8sd_pkg::*;

    token_t             entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;

    assign stat.full  = (count_reg == (FIFO_AW+1)'(FIFO_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign pop_tok    = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (push && !pop)      count_next = count_reg + 1'b1;
        else if (pop && !push) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_tok;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_next;
            if (pop)  rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/u8sd_back.sv
// Back end: pops tokens, builds the code point and holds the output register.
// Uses u8sd_pkg.
module u8sd_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  u8sd_pkg::token_t                pop_tok,
    input  u8sd_pkg::fifo_stat_t            fifo_stat,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [u8sd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import u8sd_pkg::*;

    logic [CP_W-1:0]  partial_reg, partial_next;
    logic [CNT_W-1:0] seq_reg, seq_next;
    logic             valid_reg, valid_next;
    logic [CP_W-1:0]  cp_reg, cp_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             emit;
    logic [CP_W-1:0]  shifted;

    assign pop      = !fifo_stat.empty && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {(M_TDATA_W-CP_W-CNT_W)'(0), cnt_reg, cp_reg};
    assign shifted  = {partial_reg[CP_W-7:0], pop_tok.data[5:0]};

    always_comb begin
        emit         = 1'b0;
        partial_next = partial_reg;
        seq_next     = seq_reg;
        cp_next      = cp_reg;
        cnt_next     = cnt_reg;
        case (pop_tok.kind)
            TOK_PASS: begin
                emit         = 1'b1;
                cp_next      = CP_W'(pop_tok.data);
                cnt_next     = LEN_1;
                partial_next = '0;
                seq_next     = '0;
            end
            TOK_LEAD: begin
                partial_next = CP_W'(pop_tok.data);
                seq_next     = pop_tok.len;
            end
            TOK_CONT: begin
                if (pop_tok.last) begin
                    emit         = 1'b1;
                    cp_next      = shifted;
                    cnt_next     = seq_reg;
                    partial_next = '0;
                    seq_next     = '0;
                end else begin
                    partial_next = shifted;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        valid_next = (valid_reg && !m_tready) || (pop && emit);
    end

    always_ff @(posedge aclk) begin
        if (pop && emit) begin
            cp_reg  <= cp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= 1'b0;
            partial_reg <= '0;
            seq_reg     <= '0;
        end else begin
            valid_reg <= valid_next;
            if (pop) begin
                partial_reg <= partial_next;
                seq_reg     <= seq_next;
            end
        end
    end

endmodule

FILE: sv/utf8_stream_decoder_unit.sv
// Top level of the UTF-8 stream decoder: front end, token queue, back end.
// Uses u8sd_pkg, u8sd_front, u8sd_fifo and u8sd_back.
//
// Usage:
//   s_ channel: one text byte per item in s_tdata[7:0].
//   m_ channel: one character per item; m_tdata[30:0] is the code point,
//   m_tdata[33:31] the number of bytes that formed it, upper bits zero.
//   cfg channel: cfg_data is utf8_mode (1 = decode UTF-8, 0 = pass every
//   byte through with count 1); always ready, write only while idle.
//   Throughput: one byte per cycle, sustained, in both modes, while the receiver keeps m_tready high.
//   A character's final byte is written into the queue as a token; the
//   back end then pops that token into the output register, which
//   drives m_tvalid.
//   The front end classifies each byte against its own copy of the
//   sequence position and pushes a token into a four-entry queue; the
//   back end pops one token per cycle unless a held output register stalls it.
//   When the receiver stalls, the output register holds, the queue fills
//   and s_tready drops only once all four entries are taken.
//   Reset (aresetn low, synchronous): utf8_mode returns to 1, any partial
//   sequence is dropped, the queue and output register empty.
module utf8_stream_decoder_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration: utf8_mode
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_data,
    // input items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [u8sd_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] in_byte
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [u8sd_pkg::M_TDATA_W-1:0]  m_tdata    // [30:0] code_point, [33:31] byte_count
);
    import u8sd_pkg::*;

    fifo_stat_t fifo_stat;
    token_t     push_tok;
    token_t     pop_tok;
    logic       push;
    logic       pop;
    logic       utf8_mode;

    u8sd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .fifo_stat (fifo_stat),
        .push      (push),
        .push_tok  (push_tok),
        .utf8_mode (utf8_mode)
    );

    u8sd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_tok (push_tok),
        .pop      (pop),
        .pop_tok  (pop_tok),
        .stat     (fifo_stat)
    );

    u8sd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_tok   (pop_tok),
        .fifo_stat (fifo_stat),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Every delivered character spans one to six bytes.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[33:31] != 3'd0 && m_tdata[33:31] != 3'd7))
        else $error("byte_count out of range");

    // A one-byte character never carries more than eight value bits.
    a_single_narrow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[33:31] == LEN_1) |-> (m_tdata[30:8] == '0))
        else $error("one-byte character wider than a byte");

    // In byte mode the front end only produces pass-through tokens.
    a_byte_mode_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !utf8_mode) |-> (push_tok.kind == TOK_PASS))
        else $error("byte mode produced a sequence token");

    // The queue never pops while empty, and a full queue blocks input.
    a_queue_guard: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && fifo_stat.empty) && !(push && fifo_stat.full))
        else $error("token queue overrun or underrun");

endmodule
